@@ rtl/sha_pkg.sv @@
// sha-256 hasher package: round constants, initial hash, helper functions
// and the item record passed from the byte front end to the compression engine
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned QueueDepth = 2;

  localparam logic [31:0] CountLimit = 32'hffff_fff7;
  localparam logic [7:0]  PadByte    = 8'h80;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

@@ rtl/sha_queue.sv @@
// two-entry item queue between the byte front end and the engine
// depends on sha_pkg
module sha_queue
  import sha_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o
);

  item_t      mem_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(QueueDepth));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) wptr_q <= ~wptr_q;
      if (pop_i && !empty_o) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule

@@ rtl/sha_engine.sv @@
// back end: block packing, padding, 64-round compression and digest output
// depends on sha_pkg
module sha_engine
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_index_o,
  output logic        out_last_o,
  output logic        out_ovf_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StAdd   = 5'b00100,
    StPad   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  word_t       hash_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [31:0] count_q;
  logic        ovf_q;
  logic [5:0]  round_q;
  logic [2:0]  oidx_q;
  logic        final_q;
  logic        pad2_q;
  logic        padded_q;

  logic [5:0]  used;
  logic [3:0]  wi;
  logic [1:0]  bi;
  logic        take;
  word_t       s0, s1, wnew, t1, t2, ws;
  word_t       e, a;

  assign used = count_q[8:3];
  assign wi   = used[5:2];
  assign bi   = used[1:0];
  assign take = (state_q == StIdle) && item_valid_i;
  assign item_pop_o = take;

  always_comb begin
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    ws   = w_q[0];
    e    = v_q[4];
    a    = v_q[0];
    t1   = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(round_q) + ws;
    t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign out_valid_o = (state_q == StOut);
  assign out_word_o  = hash_q[oidx_q];
  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 3'd7);
  assign out_ovf_o   = ovf_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (item_valid_i) state_d = StIdle;
      StRound: if (round_q == 6'd63) state_d = StAdd;
      StAdd:   state_d = StIdle;
      StPad:   state_d = StRound;
      StOut:   if (out_ready_i && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // w_q acts as a 16-word window: w_q[0] is the word for the current round
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (item_valid_i && item_i.has_byte && count_q < CountLimit)
          w_q[wi][8*(3-bi) +: 8] <= item_i.data;
      end
      StRound: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wnew;
        for (int i = 1; i < 8; i++) if (i != 4) v_q[i] <= v_q[i-1];
        v_q[4] <= v_q[3] + t1;
        v_q[0] <= t1 + t2;
      end
      StPad: begin
        for (int i = 0; i < 16; i++) begin
          if ((pad2_q || used < 6'd56) && i == 14) begin
            w_q[i] <= '0;
          end else if ((pad2_q || used < 6'd56) && i == 15) begin
            w_q[i] <= count_q;
          end else if (pad2_q) begin
            w_q[i] <= '0;
          end else if (4'(i) == wi) begin
            case (bi)
              2'd0:    w_q[i] <= {PadByte, 24'd0};
              2'd1:    w_q[i] <= {w_q[i][31:24], PadByte, 16'd0};
              2'd2:    w_q[i] <= {w_q[i][31:16], PadByte, 8'd0};
              default: w_q[i] <= {w_q[i][31:8], PadByte};
            endcase
          end else if (4'(i) > wi) begin
            w_q[i] <= '0;
          end
        end
        for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
      end
      default: begin
      end
    endcase
    if (take && item_i.has_byte && count_q < CountLimit && used == 6'd63)
      for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
      count_q  <= '0;
      ovf_q    <= 1'b0;
      round_q  <= '0;
      oidx_q   <= '0;
      final_q  <= 1'b0;
      pad2_q   <= 1'b0;
      padded_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            round_q  <= '0;
            oidx_q   <= '0;
            pad2_q   <= 1'b0;
            padded_q <= 1'b0;
            final_q  <= item_i.eom;
            if (item_i.has_byte) begin
              if (count_q >= CountLimit) ovf_q <= 1'b1;
              else count_q <= count_q + 32'd8;
            end
            if (item_i.has_byte && count_q < CountLimit && used == 6'd63)
              state_q <= StRound;
            else if (item_i.eom)
              state_q <= StPad;
          end
        end
        StRound: begin
          round_q <= round_q + 6'd1;
          state_q <= state_d;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
          round_q <= '0;
          if (!final_q) begin
            state_q <= StIdle;
          end else if (!padded_q) begin
            state_q <= StPad;
          end else if (pad2_q || used < 6'd56) begin
            state_q <= StOut;
          end else begin
            pad2_q  <= 1'b1;
            state_q <= StPad;
          end
        end
        StPad: begin
          // pad2_q stays once set so the last block is length-only
          padded_q <= 1'b1;
          state_q  <= state_d;
        end
        StOut: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
              count_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
          state_q <= state_d;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ rtl/sha256_message_hasher_top.sv @@
// top level of the sha-256 message hasher: input queue and compression engine
// depends on sha_pkg, sha_queue, sha_engine
//
// Bytes enter through the input stream and are queued two deep ahead of the
// engine. A byte that does not complete a block is absorbed while the engine
// stays idle; a byte that completes a 64-byte block starts a compression by the
// single round unit, doing one of 64 rounds per cycle, and then the final hash
// addition. An end-of-message item adds one or two padded blocks and then
// eight digest items, word 0 first. Bytes past the 32-bit bit count
// limit are dropped and flagged on every digest word of that message.
module sha256_message_hasher_top
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_message
  input  logic        s_axis_tuser,   // has_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_axis_tlast,   // last_word
  output logic        m_axis_tuser    // length_overflow
);

  item_t       in_item, q_item;
  logic        q_full, q_empty, q_pop;
  logic [31:0] dig_word;
  logic [2:0]  dig_idx;

  assign in_item.data     = s_axis_tdata;
  assign in_item.has_byte = s_axis_tuser;
  assign in_item.eom      = s_axis_tlast;
  assign s_axis_tready    = !q_full;

  sha_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_item),
    .empty_o     (q_empty)
  );

  sha_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (dig_word),
    .out_index_o  (dig_idx),
    .out_last_o   (m_axis_tlast),
    .out_ovf_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, dig_idx, dig_word};

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("last flag out of step with word index");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("digest words not consecutive");

  a_no_pop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !q_pop)
    else $error("item taken during digest output");

endmodule
